### sv/wssg_pkg.sv
// Shared types and constants for the wireframe sphere segment generator.
`timescale 1ns / 1ps
`default_nettype none

package wssg_pkg;

	typedef enum logic [2:0] {
		REG_CENTER_X   = 3'd0,
		REG_CENTER_Y   = 3'd1,
		REG_CENTER_Z   = 3'd2,
		REG_RADIUS     = 3'd3,
		REG_LINE_COLOR = 3'd4,
		REG_SLICES     = 3'd5,
		REG_RINGS      = 3'd6
	} cfg_reg_t;

	typedef logic signed [17:0] trig_t;
	typedef logic signed [31:0] coord_t;

	localparam int unsigned SIN_LAT    = 17;
	localparam int unsigned MIN_SLICES = 3;
	localparam int unsigned MIN_RINGS  = 2;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

endpackage

`default_nettype wire

### sv/wssg_ifs.sv
// Handshake channel interfaces: configuration writes, cell requests, vertex beats.
`timescale 1ns / 1ps
`default_nettype none

interface wssg_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface wssg_cell_if;
	logic       valid;
	logic       ready;
	logic [7:0] slice_index;
	logic [7:0] ring_index;
	modport source (output valid, output slice_index, output ring_index, input ready);
	modport sink (input valid, input slice_index, input ring_index, output ready);
endinterface

interface wssg_vert_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vertex_x;
	logic signed [31:0] vertex_y;
	logic signed [31:0] vertex_z;
	logic [31:0]        vertex_color;
	logic               last_vertex;
	logic               bad_index;
	modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
		output vertex_color, output last_vertex, output bad_index, input ready);
	modport sink (input valid, input vertex_x, input vertex_y, input vertex_z,
		input vertex_color, input last_vertex, input bad_index, output ready);
endinterface

`default_nettype wire

### sv/wssg_sin.sv
// Pipelined Q16 sine of a 32-bit turn phase (Taylor series, Horner form in Q30).
`timescale 1ns / 1ps
`default_nettype none

module wssg_sin import wssg_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] phase,
	output trig_t       sin_val
);

	typedef struct packed {
		logic [30:0] x;
		logic [31:0] x2;
		logic        neg;
	} lane_t;

	localparam logic [31:0] DIV_K [0:3] = '{32'd72, 32'd42, 32'd20, 32'd6};
	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [17:0] SIN_CAP     = 18'd65536;

	logic [30:0] u_s1;
	logic        neg_s1;
	logic [30:0] x_s2;
	logic        neg_s2;
	lane_t       lane_s3;
	lane_t       lane_a [0:3];
	lane_t       lane_b [0:3];
	lane_t       lane_c [0:3];
	logic [31:0] pr_s [0:3];
	logic [31:0] prd_s [0:3];
	logic [31:0] qe_s [0:3];
	logic [30:0] t_s [0:3];
	logic [30:0] v_s16;
	logic        neg_s16;
	trig_t       out_s17;

	logic [30:0] u_d;
	logic [61:0] px;
	logic [61:0] pxx;
	logic [61:0] pv;
	logic [31:0] rnd;
	logic [17:0] mag;
	logic [17:0] capped;

	assign u_d = phase[30] ? (ONE_Q30 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
	assign px  = 62'(u_s1) * 62'(HALF_PI_Q30);
	assign pxx = 62'(x_s2) * 62'(x_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1         <= u_d;
			neg_s1       <= phase[31];
			x_s2         <= px[60:30];
			neg_s2       <= neg_s1;
			lane_s3.x    <= x_s2;
			lane_s3.x2   <= pxx[61:30];
			lane_s3.neg  <= neg_s2;
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_round
		localparam logic [31:0] MUL = 32'((64'd1 << 34) / 64'(DIV_K[k]));
		lane_t       lin;
		logic [30:0] tin;
		logic [62:0] pp;
		logic [63:0] pq;
		logic [31:0] rem;
		logic [31:0] quo;

		if (k == 0) begin : g_first
			assign lin = lane_s3;
			assign tin = ONE_Q30;
		end else begin : g_next
			assign lin = lane_c[k-1];
			assign tin = t_s[k-1];
		end

		assign pp  = 63'(lin.x2) * 63'(tin);
		assign pq  = 64'(pr_s[k]) * 64'(MUL);
		assign rem = prd_s[k] - (qe_s[k] * DIV_K[k]);
		assign quo = (rem >= DIV_K[k]) ? (qe_s[k] + 32'd1) : qe_s[k];

		always_ff @(posedge clk) begin
			if (en) begin
				lane_a[k] <= lin;
				pr_s[k]   <= pp[61:30];
				lane_b[k] <= lane_a[k];
				prd_s[k]  <= pr_s[k];
				qe_s[k]   <= {2'b00, pq[63:34]};
				lane_c[k] <= lane_b[k];
				t_s[k]    <= ONE_Q30 - quo[30:0];
			end
		end
	end

	assign pv     = 62'(lane_c[3].x) * 62'(t_s[3]);
	assign rnd    = 32'(v_s16) + 32'd8192;
	assign mag    = rnd[31:14];
	assign capped = (mag > SIN_CAP) ? SIN_CAP : mag;

	always_ff @(posedge clk) begin
		if (en) begin
			v_s16   <= pv[60:30];
			neg_s16 <= lane_c[3].neg;
			out_s17 <= neg_s16 ? -$signed(capped) : $signed(capped);
		end
	end

	assign sin_val = out_s17;

endmodule

`default_nettype wire

### sv/wireframe_sphere_segment_generator.sv
// Top level: UV-sphere wireframe segment generator, one cell in, 1/2/4 vertex beats out.
//
// Channels: cfg writes registers (center x/y/z, radius, color, slice and ring counts);
// cells carries one (slice_index, ring_index) request per beat; verts returns vertices.
// A valid cell yields the meridian segment p0-p1 and, below the last ring, the ring
// segment p1-p2: 4 beats, or 2 on the last ring. An index at or past its effective
// count yields a single zeroed beat with bad_index and last_vertex set.
// Throughput: one vertex per cycle unless verts stalls; the single vertex channel
// sets this. The cell register expands a cell into vertex beats while the
// 27-stage pipeline (division by the counts, sine/cosine, scaling, saturation)
// works on earlier beats.
// Reset: registers return to center 0, radius 1.0, color all ones, 16 slices, 16 rings;
// the pipeline empties. The config port is always ready.
// Stall: when verts is not taken the whole pipeline holds and cells drops ready;
// nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module wireframe_sphere_segment_generator import wssg_pkg::*; #(
	parameter int unsigned COUNT_MAX = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	wssg_cfg_if.sink    cfg,
	wssg_cell_if.sink   cells,
	wssg_vert_if.source verts
);

	localparam int unsigned CNT_CAP = (COUNT_MAX > 255) ? 255 : COUNT_MAX;
	localparam int unsigned NST     = 5 + SIN_LAT + 5;

	typedef struct packed {
		logic vld;
		logic bad;
		logic last;
	} band_t;

	coord_t      cx_q, cy_q, cz_q;
	logic [30:0] rad_q;
	logic [31:0] color_q;
	logic [7:0]  slices_q, rings_q;

	logic        cell_vld_q;
	logic [1:0]  beat_q;
	logic [7:0]  j_q, i_q;

	logic        en;
	logic [7:0]  s_cap, r_cap, s_eff, r_eff;
	logic        bad_c, ring_end_c, last_beat;
	logic [8:0]  n_p, n_z, rem_p_d, rem_z_d;
	logic [9:0]  div_p, div_z;

	band_t       band_s [1:NST];
	logic [8:0]  rem_p_s1, rem_z_s1;
	logic [8:0]  rem_p_s [2:5];
	logic [8:0]  rem_z_s [2:5];
	logic [31:0] quo_p_s [2:5];
	logic [31:0] quo_z_s [2:5];

	trig_t       sin_p, cos_p, sin_z, cos_z;

	logic [47:0] prod_ar_s23, prod_ay_s23;
	logic        neg_ar_s23, neg_ay_s23;
	trig_t       sin_z_s23, cos_z_s23, sin_z_s24, cos_z_s24;
	logic signed [32:0] ar_s24, ay_s24, ay_s25, ay_s26;
	logic [48:0] prod_x_s25, prod_z_s25;
	logic        neg_x_s25, neg_z_s25;
	logic signed [33:0] dx_s26, dz_s26;
	coord_t      x_s27, y_s27, z_s27;
	logic [31:0] color_s27;

	logic [47:0] sum_ar, sum_ay;
	logic [48:0] sum_x, sum_z;
	logic [16:0] mag_sp, mag_cp;
	logic [31:0] mag_ar;

	function automatic logic [16:0] div8(input logic [8:0] rem_in, input logic [9:0] dvs);
		logic [8:0] rem;
		logic [9:0] sh;
		logic [7:0] q;
		rem = rem_in;
		q   = '0;
		for (int b = 7; b >= 0; b--) begin
			sh = {rem, 1'b0};
			if (sh >= dvs) begin
				rem  = 9'(sh - dvs);
				q[b] = 1'b1;
			end else begin
				rem = sh[8:0];
			end
		end
		return {rem, q};
	endfunction

	function automatic logic [16:0] mag17(input trig_t t);
		logic [17:0] a;
		a = t[17] ? 18'(-t) : 18'(t);
		return a[16:0];
	endfunction

	function automatic coord_t sat32(input logic signed [34:0] s);
		if (s > 35'sd2147483647) begin
			return 32'h7FFF_FFFF;
		end else if (s < -35'sd2147483648) begin
			return 32'h8000_0000;
		end
		return s[31:0];
	endfunction

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			cz_q     <= '0;
			rad_q    <= 31'd65536;
			color_q  <= 32'hFFFF_FFFF;
			slices_q <= 8'd16;
			rings_q  <= 8'd16;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_CENTER_X:   cx_q     <= cfg.data;
				REG_CENTER_Y:   cy_q     <= cfg.data;
				REG_CENTER_Z:   cz_q     <= cfg.data;
				REG_RADIUS:     rad_q    <= cfg.data[30:0];
				REG_LINE_COLOR: color_q  <= cfg.data;
				REG_SLICES:     slices_q <= cfg.data[7:0];
				REG_RINGS:      rings_q  <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// effective counts and beat decode
	assign s_cap = (32'(slices_q) > CNT_CAP) ? 8'(CNT_CAP) : slices_q;
	assign r_cap = (32'(rings_q) > CNT_CAP) ? 8'(CNT_CAP) : rings_q;
	assign s_eff = (32'(s_cap) < MIN_SLICES) ? 8'(MIN_SLICES) : s_cap;
	assign r_eff = (32'(r_cap) < MIN_RINGS) ? 8'(MIN_RINGS) : r_cap;

	assign bad_c      = (j_q >= s_eff) || (i_q >= r_eff);
	assign ring_end_c = ({1'b0, i_q} + 9'd1) >= {1'b0, r_eff};
	assign last_beat  = bad_c ? (beat_q == 2'd0)
	                  : (ring_end_c ? (beat_q == 2'd1) : (beat_q == 2'd3));

	assign n_p     = (beat_q == 2'd0) ? {1'b0, i_q} : ({1'b0, i_q} + 9'd1);
	assign n_z     = (beat_q == 2'd3) ? ({1'b0, j_q} + 9'd1) : {1'b0, j_q};
	assign rem_p_d = bad_c ? 9'd0 : n_p;
	assign rem_z_d = (bad_c || (n_z == {1'b0, s_eff})) ? 9'd0 : n_z;
	assign div_p   = {1'b0, r_eff, 1'b0};
	assign div_z   = {2'b00, s_eff};

	assign en          = !band_s[NST].vld || verts.ready;
	assign cells.ready = en && (!cell_vld_q || last_beat);

	// cell register: expand one cell into vertex beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_vld_q <= 1'b0;
			beat_q     <= 2'd0;
		end else if (en) begin
			if (cells.valid && cells.ready) begin
				cell_vld_q <= 1'b1;
				beat_q     <= 2'd0;
			end else if (cell_vld_q) begin
				if (last_beat) begin
					cell_vld_q <= 1'b0;
				end else begin
					beat_q <= beat_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cells.valid && cells.ready) begin
			j_q <= cells.slice_index;
			i_q <= cells.ring_index;
		end
	end

	// control line: valid, bad and last travel with the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NST; k++) begin
				band_s[k] <= '0;
			end
		end else if (en) begin
			band_s[1] <= '{vld: cell_vld_q, bad: bad_c, last: last_beat};
			for (int k = 2; k <= NST; k++) begin
				band_s[k] <= band_s[k-1];
			end
		end
	end

	// phase division, eight quotient bits a stage
	always_ff @(posedge clk) begin
		if (en) begin
			rem_p_s1 <= rem_p_d;
			rem_z_s1 <= rem_z_d;
		end
	end

	for (genvar k = 2; k <= 5; k++) begin : g_div
		logic [16:0] step_p, step_z;
		logic [8:0]  rin_p, rin_z;
		logic [31:0] qin_p, qin_z;

		if (k == 2) begin : g_first
			assign rin_p = rem_p_s1;
			assign rin_z = rem_z_s1;
			assign qin_p = '0;
			assign qin_z = '0;
		end else begin : g_next
			assign rin_p = rem_p_s[k-1];
			assign rin_z = rem_z_s[k-1];
			assign qin_p = quo_p_s[k-1];
			assign qin_z = quo_z_s[k-1];
		end

		assign step_p = div8(rin_p, div_p);
		assign step_z = div8(rin_z, div_z);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_p_s[k] <= step_p[16:8];
				rem_z_s[k] <= step_z[16:8];
				quo_p_s[k] <= {qin_p[23:0], step_p[7:0]};
				quo_z_s[k] <= {qin_z[23:0], step_z[7:0]};
			end
		end
	end

	// sine and cosine of polar and azimuth phases
	wssg_sin u_sin_p (.clk(clk), .en(en), .phase(quo_p_s[5]), .sin_val(sin_p));
	wssg_sin u_cos_p (.clk(clk), .en(en), .phase(quo_p_s[5] + QUARTER_TURN), .sin_val(cos_p));
	wssg_sin u_sin_z (.clk(clk), .en(en), .phase(quo_z_s[5]), .sin_val(sin_z));
	wssg_sin u_cos_z (.clk(clk), .en(en), .phase(quo_z_s[5] + QUARTER_TURN), .sin_val(cos_z));

	// scale by radius, then by azimuth, then saturate around the center
	assign mag_sp = mag17(sin_p);
	assign mag_cp = mag17(cos_p);
	assign sum_ar = prod_ar_s23 + 48'd32768;
	assign sum_ay = prod_ay_s23 + 48'd32768;
	assign mag_ar = ar_s24[32] ? 32'(-ar_s24) : ar_s24[31:0];
	assign sum_x  = prod_x_s25 + 49'd32768;
	assign sum_z  = prod_z_s25 + 49'd32768;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_ar_s23 <= 48'(rad_q) * 48'(mag_sp);
			prod_ay_s23 <= 48'(rad_q) * 48'(mag_cp);
			neg_ar_s23  <= sin_p[17];
			neg_ay_s23  <= cos_p[17];
			sin_z_s23   <= sin_z;
			cos_z_s23   <= cos_z;

			ar_s24    <= neg_ar_s23 ? -$signed({1'b0, sum_ar[47:16]})
			                        : $signed({1'b0, sum_ar[47:16]});
			ay_s24    <= neg_ay_s23 ? -$signed({1'b0, sum_ay[47:16]})
			                        : $signed({1'b0, sum_ay[47:16]});
			sin_z_s24 <= sin_z_s23;
			cos_z_s24 <= cos_z_s23;

			prod_x_s25 <= 49'(mag_ar) * 49'(mag17(sin_z_s24));
			prod_z_s25 <= 49'(mag_ar) * 49'(mag17(cos_z_s24));
			neg_x_s25  <= ar_s24[32] ^ sin_z_s24[17];
			neg_z_s25  <= ar_s24[32] ^ cos_z_s24[17];
			ay_s25     <= ay_s24;

			dx_s26 <= neg_x_s25 ? -$signed({1'b0, sum_x[48:16]}) : $signed({1'b0, sum_x[48:16]});
			dz_s26 <= neg_z_s25 ? -$signed({1'b0, sum_z[48:16]}) : $signed({1'b0, sum_z[48:16]});
			ay_s26 <= ay_s25;

			if (band_s[NST-1].bad) begin
				x_s27     <= '0;
				y_s27     <= '0;
				z_s27     <= '0;
				color_s27 <= '0;
			end else begin
				x_s27     <= sat32(35'(cx_q) + 35'(dx_s26));
				y_s27     <= sat32(35'(cy_q) + 35'(ay_s26));
				z_s27     <= sat32(35'(cz_q) + 35'(dz_s26));
				color_s27 <= color_q;
			end
		end
	end

	assign verts.valid        = band_s[NST].vld;
	assign verts.vertex_x     = x_s27;
	assign verts.vertex_y     = y_s27;
	assign verts.vertex_z     = z_s27;
	assign verts.vertex_color = color_s27;
	assign verts.last_vertex  = band_s[NST].last;
	assign verts.bad_index    = band_s[NST].bad;

	a_accept_loads_cell: assert property (@(posedge clk) disable iff (!arst_n)
		cells.valid && cells.ready |=> cell_vld_q && (beat_q == 2'd0))
		else $error("accepted cell not loaded");

	a_bad_beat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		verts.valid && verts.bad_index |-> verts.last_vertex && (verts.vertex_x == 0)
			&& (verts.vertex_color == 0))
		else $error("bad beat not a zeroed final vertex");

	a_ready_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cells.ready |-> (!band_s[NST].vld || verts.ready))
		else $error("cell taken while pipeline stalled");

endmodule

`default_nettype wire
